[hdl/fds_pkg.sv]
package fds_pkg;

    localparam int NAME_CAPACITY = 12;
    localparam int SEEN_W        = 17;
    localparam int CFG_INDEX_W   = 8;
    localparam int CFG_DATA_W    = 64;

    localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_END      = 8'h00;
    localparam logic [7:0] CH_DELETED  = 8'hE5;
    localparam logic [7:0] CH_KANJI_E5 = 8'h05;
    localparam logic [7:0] ATTR_LFN    = 8'h0F;

    localparam int BASE_LEN = 8;
    localparam int EXT_LEN  = 3;

    // result status codes
    localparam logic [1:0] ST_MISS  = 2'd0;
    localparam logic [1:0] ST_FOUND = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_MODE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_BASE  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_EXT   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_INDEX = 8'd3;

    typedef struct packed {
        logic        first_entry;
        logic [63:0] entry_base;
        logic [23:0] entry_ext;
        logic [7:0]  entry_attr;
        logic [15:0] cluster_high;
        logic [15:0] cluster_low;
        logic [31:0] entry_size;
    } entry_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] first_cluster;
        logic        is_dir;
        logic [31:0] file_size;
        logic [7:0]  name_char;
        logic        char_valid;
        logic [3:0]  name_length;
        logic        last;
    } result_t;

    typedef struct packed {
        logic        search_mode;
        logic [63:0] target_base;
        logic [23:0] target_ext;
        logic [15:0] target_index;
    } cfg_t;

    // one classified entry waiting for the back end
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] first_cluster;
        logic        is_dir;
        logic [31:0] file_size;
        logic        is_name;
        logic [63:0] base;
        logic [23:0] ext;
        logic [3:0]  base_len;
        logic [1:0]  ext_len;
        logic [3:0]  name_len;
    } job_t;

endpackage

[hdl/fds_front.sv]
module fds_front #(
    parameter int NAME_CAPACITY = fds_pkg::NAME_CAPACITY
) (
    input  logic            clk,
    input  logic            rst_n,
    input  fds_pkg::cfg_t   cfg,
    input  logic            accept,
    input  fds_pkg::entry_t entry,
    output fds_pkg::job_t   job
);

    logic [fds_pkg::SEEN_W-1:0] seen_reg, seen_next;
    logic                       done_reg, done_next;

    logic [fds_pkg::SEEN_W-1:0] eff_seen, seen_inc;
    logic                       eff_done;
    logic [7:0]                 b0;
    logic                       skip, dir;
    logic [63:0]                cmp_base;
    logic [3:0]                 base_len, total_len;
    logic [1:0]                 ext_len;

    assign eff_seen = entry.first_entry ? '0 : seen_reg;
    assign eff_done = entry.first_entry ? 1'b0 : done_reg;
    assign seen_inc = (eff_seen == fds_pkg::SEEN_MAX) ? eff_seen
                                                      : eff_seen + 1'b1;
    assign b0   = entry.entry_base[63:56];
    assign dir  = entry.entry_attr[4];
    assign skip = (b0 == fds_pkg::CH_DELETED) || (entry.entry_attr == fds_pkg::ATTR_LFN)
                  || entry.entry_attr[3];
    assign cmp_base = (b0 == fds_pkg::CH_KANJI_E5)
                      ? {fds_pkg::CH_DELETED, entry.entry_base[55:0]} : entry.entry_base;

    // trailing-space trim of base and extension
    always_comb
    begin
        base_len = '0;
        ext_len  = '0;
        for (int i = 0; i < fds_pkg::BASE_LEN; i++)
        begin
            if (entry.entry_base[63-8*i -: 8] != fds_pkg::CH_SPACE)
                base_len = 4'(i + 1);
        end
        for (int i = 0; i < fds_pkg::EXT_LEN; i++)
        begin
            if (entry.entry_ext[23-8*i -: 8] != fds_pkg::CH_SPACE)
                ext_len = 2'(i + 1);
        end
    end

    assign total_len = base_len + ((ext_len != 2'd0) ? ({2'b00, ext_len} + 4'd1) : 4'd0);

    always_comb
    begin
        job           = '0;
        job.status    = fds_pkg::ST_MISS;
        job.base      = entry.entry_base;
        job.ext       = entry.entry_ext;
        job.base_len  = base_len;
        job.ext_len   = ext_len;
        job.name_len  = (total_len > 4'(NAME_CAPACITY)) ? 4'(NAME_CAPACITY) : total_len;
        seen_next     = eff_seen;
        done_next     = eff_done;
        if (eff_done)
        begin
            job.status = fds_pkg::ST_DONE;
        end
        else if (b0 == fds_pkg::CH_END)
        begin
            job.status = fds_pkg::ST_END;
            done_next  = 1'b1;
        end
        else if (skip)
        begin
            job.status = fds_pkg::ST_MISS;
        end
        else if (!cfg.search_mode)
        begin
            seen_next = seen_inc;
            if (cmp_base == cfg.target_base && entry.entry_ext == cfg.target_ext)
            begin
                job.status        = fds_pkg::ST_FOUND;
                job.first_cluster = {entry.cluster_high, entry.cluster_low};
                job.is_dir        = dir;
                job.file_size     = dir ? 32'd0 : entry.entry_size;
                done_next         = 1'b1;
            end
        end
        else if (eff_seen != {1'b0, cfg.target_index})
        begin
            seen_next = seen_inc;
        end
        else
        begin
            job.status  = fds_pkg::ST_FOUND;
            job.is_dir  = dir;
            job.is_name = 1'b1;
            done_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (accept)
        begin
            seen_reg <= seen_next;
            done_reg <= done_next;
        end
    end

endmodule

[hdl/fds_queue.sv]
module fds_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fds_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output fds_pkg::job_t head_job
);

    fds_pkg::job_t slot_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

[hdl/fds_back.sv]
module fds_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  fds_pkg::job_t    head_job,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_ready,
    output fds_pkg::result_t result
);

    logic             out_valid_reg;
    fds_pkg::result_t out_reg, out_next;
    logic [3:0]       pos_reg;
    logic             advance, is_last;
    logic [7:0]       base_char, ext_char;
    logic [3:0]       ext_pos;

    assign advance = head_valid && (!out_valid_reg || result_ready);
    assign is_last = !head_job.is_name || (head_job.name_len == 4'd0)
                     || (pos_reg == head_job.name_len - 4'd1);
    assign pop     = advance && is_last;

    assign ext_pos  = pos_reg - head_job.base_len - 4'd1;
    assign ext_char = head_job.ext[23 - 8*ext_pos[1:0] -: 8];

    always_comb
    begin
        base_char = head_job.base[63 - 8*pos_reg[2:0] -: 8];
        if (pos_reg == 4'd0 && base_char == fds_pkg::CH_KANJI_E5)
            base_char = fds_pkg::CH_DELETED;
    end

    always_comb
    begin
        out_next               = '0;
        out_next.status        = head_job.status;
        out_next.first_cluster = head_job.first_cluster;
        out_next.is_dir        = head_job.is_dir;
        out_next.file_size     = head_job.file_size;
        out_next.last          = is_last;
        if (head_job.is_name && head_job.name_len != 4'd0)
        begin
            out_next.char_valid = 1'b1;
            if (pos_reg < head_job.base_len)
                out_next.name_char = base_char;
            else if (pos_reg == head_job.base_len)
                out_next.name_char = fds_pkg::CH_DOT;
            else
                out_next.name_char = ext_char;
            if (is_last)
                out_next.name_length = head_job.name_len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
            if (pop)
                pos_reg <= '0;
            else if (advance)
                pos_reg <= pos_reg + 4'd1;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[hdl/fat_dir_entry_scanner_core.sv]
// An accepted entry's job is registered in the job queue, then its result in the output register.
// Throughput: one entry per cycle while the queue has room; an index-mode hit emits
// one character per cycle while result_ready is high, so it holds the back end for
// its whole name while the 2-deep job queue keeps accepting entries until it fills.
// Reset (rst_n, async, active low): clears the visible count, the done flag, all
// configuration registers, the job queue and the output valid flag.
module fat_dir_entry_scanner_core #(
    parameter int NAME_CAPACITY = fds_pkg::NAME_CAPACITY
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            entry_valid,
    output logic                            entry_ready,
    input  fds_pkg::entry_t                 entry,
    output logic                            result_valid,
    input  logic                            result_ready,
    output fds_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fds_pkg::CFG_DATA_W-1:0]  cfg_data
);

    fds_pkg::cfg_t cfg_reg;
    fds_pkg::job_t front_job, head_job;
    logic          q_full, head_valid, pop, accept;

    assign cfg_ready   = 1'b1;
    assign entry_ready = !q_full;
    assign accept      = entry_valid && entry_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fds_pkg::REG_SEARCH_MODE:  cfg_reg.search_mode  <= cfg_data[0];
                fds_pkg::REG_TARGET_BASE:  cfg_reg.target_base  <= cfg_data;
                fds_pkg::REG_TARGET_EXT:   cfg_reg.target_ext   <= cfg_data[23:0];
                fds_pkg::REG_TARGET_INDEX: cfg_reg.target_index <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    fds_front #(
        .NAME_CAPACITY(NAME_CAPACITY)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .accept(accept),
        .entry (entry),
        .job   (front_job)
    );

    fds_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_job  (front_job),
        .full      (q_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_job  (head_job)
    );

    fds_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    // anything but a hit is a single-result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != fds_pkg::ST_FOUND |-> result.last)
        else $error("non-found result without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.char_valid || result.first_cluster != 32'd0)
        |-> result.status == fds_pkg::ST_FOUND)
        else $error("payload fields set on a non-found result");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.name_length != 4'd0
        |-> result.last && result.char_valid)
        else $error("name length outside the last character");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

endmodule

[tb/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAIL_CYCLES  = 6;
    localparam int RANDOM_ITEMS = 330;
    localparam int LONG_INDEX   = 24;
    localparam int MAX_PRINTS   = 40;

    // attribute bits used to build entries
    localparam logic [7:0] ATTR_ARCHIVE = 8'h20;
    localparam logic [7:0] ATTR_DIR     = 8'h10;
    localparam logic [7:0] ATTR_LABEL   = 8'h08;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            entry_valid  = 1'b0;
    logic                            entry_ready;
    fds_pkg::entry_t                 entry        = '0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    fds_pkg::result_t                result;
    logic                            cfg_valid    = 1'b0;
    logic                            cfg_ready;
    logic [fds_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [fds_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

    fds_pkg::entry_t  entry_backlog[$];
    fds_pkg::result_t predicted_results[$];

    bit calm           = 1'b0;
    int send_gap       = 0;
    int stall_left     = 0;
    int mismatches     = 0;
    int queued_items   = 0;
    int accepted_items = 0;
    int results_seen   = 0;
    int found_count    = 0;
    int chars_seen     = 0;

    // shadow of the block's registers and scan state
    logic                       by_index   = 1'b0;
    logic [63:0]                want_base  = '0;
    logic [23:0]                want_ext   = '0;
    logic [15:0]                want_index = '0;
    logic [fds_pkg::SEEN_W-1:0] seen_count = '0;
    logic                       scan_over  = 1'b0;

    fat_dir_entry_scanner_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (entry_valid),
        .entry_ready  (entry_ready),
        .entry        (entry),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_char();
        case ($urandom_range(0, 7)) inside
            [0:2]:   return "A" + 8'($urandom_range(0, 25));
            [3:4]:   return "0" + 8'($urandom_range(0, 9));
            5:       return 8'($urandom_range(1, 255));
            6:       return "_";
            default: return fds_pkg::CH_SPACE;
        endcase
    endfunction

    function automatic logic [63:0] rand_base();
        logic [63:0] b;
        int          len;
        int          k;
        len = $urandom_range(0, fds_pkg::BASE_LEN);
        for (k = 0; k < fds_pkg::BASE_LEN; k++)
            b[8*(7-k) +: 8] = (k < len) ? rand_char() : fds_pkg::CH_SPACE;
        if (b[63:56] == fds_pkg::CH_END || b[63:56] == fds_pkg::CH_DELETED)
            b[63:56] = "Q";
        if ($urandom_range(0, 11) == 0)
            b[63:56] = fds_pkg::CH_KANJI_E5;
        return b;
    endfunction

    function automatic logic [23:0] rand_ext();
        logic [23:0] x;
        int          len;
        int          k;
        len = $urandom_range(0, fds_pkg::EXT_LEN);
        for (k = 0; k < fds_pkg::EXT_LEN; k++)
            x[8*(2-k) +: 8] = (k < len) ? rand_char() : fds_pkg::CH_SPACE;
        return x;
    endfunction

    function automatic fds_pkg::entry_t visible_entry(input logic first);
        fds_pkg::entry_t e;
        e.first_entry  = first;
        e.entry_base   = rand_base();
        e.entry_ext    = rand_ext();
        e.entry_attr   = 8'($urandom) & ~ATTR_LABEL;
        e.cluster_high = 16'($urandom);
        e.cluster_low  = 16'($urandom);
        e.entry_size   = ($urandom_range(0, 5) == 0) ? '0 : 32'($urandom);
        return e;
    endfunction

    function automatic fds_pkg::entry_t mk(input logic first, input logic [63:0] b,
                                           input logic [23:0] x, input logic [7:0] a);
        fds_pkg::entry_t e;
        e            = visible_entry(first);
        e.entry_base = b;
        e.entry_ext  = x;
        e.entry_attr = a;
        return e;
    endfunction

    // skipped, noise or plain visible entry
    function automatic fds_pkg::entry_t filler(input logic first);
        fds_pkg::entry_t e;
        e = visible_entry(first);
        case ($urandom_range(0, 9))
            0: e.entry_base[63:56] = fds_pkg::CH_DELETED;
            1: e.entry_attr = fds_pkg::ATTR_LFN;
            2: e.entry_attr = 8'($urandom) | ATTR_LABEL;
            3:
            begin
                e.first_entry  = 1'($urandom);
                e.entry_base   = {$urandom, $urandom};
                e.entry_ext    = 24'($urandom);
                e.entry_attr   = 8'($urandom);
            end
            default: ;
        endcase
        return e;
    endfunction

    function automatic void queue_entry(input fds_pkg::entry_t e);
        entry_backlog.push_back(e);
        queued_items++;
    endfunction

    // one directory: entries, maybe the target, maybe the end mark, then leftovers
    function automatic void build_scan();
        fds_pkg::entry_t e;
        int              len;
        int              hit_at;
        int              k;
        len    = $urandom_range(0, 9);
        hit_at = -1;
        if (!by_index && $urandom_range(0, 9) < 7)
            hit_at = $urandom_range(0, len);
        for (k = 0; k <= len; k++)
        begin
            if (k == hit_at)
            begin
                e            = visible_entry(k == 0);
                e.entry_base = want_base;
                e.entry_ext  = want_ext;
                if (want_base[63:56] == fds_pkg::CH_DELETED)
                    e.entry_base[63:56] = fds_pkg::CH_KANJI_E5;
            end
            else
                e = filler(k == 0);
            queue_entry(e);
        end
        if ($urandom_range(0, 9) < 6)
        begin
            e = visible_entry(1'b0);
            e.entry_base[63:56] = fds_pkg::CH_END;
            queue_entry(e);
        end
        for (k = $urandom_range(0, 2); k > 0; k--)
            queue_entry(filler(1'b0));
    endfunction

    function automatic void predict_scan_results(input fds_pkg::entry_t e);
        fds_pkg::result_t r;
        logic [7:0]       b0;
        logic [7:0]       ch;
        logic [63:0]      cmp;
        logic [7:0]       name_buf [fds_pkg::NAME_CAPACITY];
        int               nlen;
        int               xlen;
        int               n;
        int               k;
        b0     = e.entry_base[63:56];
        r      = '0;
        r.last = 1'b1;
        if (e.first_entry)
        begin
            seen_count = '0;
            scan_over  = 1'b0;
        end
        if (scan_over)
            r.status = fds_pkg::ST_DONE;
        else if (b0 == fds_pkg::CH_END)
        begin
            scan_over = 1'b1;
            r.status  = fds_pkg::ST_END;
        end
        else if (b0 == fds_pkg::CH_DELETED || e.entry_attr == fds_pkg::ATTR_LFN
                 || (e.entry_attr & ATTR_LABEL) != 0)
            r.status = fds_pkg::ST_MISS;
        else if (!by_index)
        begin
            cmp = e.entry_base;
            if (b0 == fds_pkg::CH_KANJI_E5)
                cmp[63:56] = fds_pkg::CH_DELETED;
            if (seen_count != fds_pkg::SEEN_MAX)
                seen_count++;
            if (cmp == want_base && e.entry_ext == want_ext)
            begin
                scan_over       = 1'b1;
                r.status        = fds_pkg::ST_FOUND;
                r.first_cluster = {e.cluster_high, e.cluster_low};
                r.is_dir        = e.entry_attr[4];
                r.file_size     = e.entry_attr[4] ? '0 : e.entry_size;
            end
        end
        else if (seen_count != {1'b0, want_index})
        begin
            if (seen_count != fds_pkg::SEEN_MAX)
                seen_count++;
        end
        else
        begin
            // trim trailing spaces, then lay out NAME.EXT up to capacity
            nlen = fds_pkg::BASE_LEN;
            while (nlen > 0
                   && e.entry_base[8*(fds_pkg::BASE_LEN-nlen) +: 8] == fds_pkg::CH_SPACE)
                nlen--;
            xlen = fds_pkg::EXT_LEN;
            while (xlen > 0
                   && e.entry_ext[8*(fds_pkg::EXT_LEN-xlen) +: 8] == fds_pkg::CH_SPACE)
                xlen--;
            n = 0;
            for (k = 0; k < nlen && n < fds_pkg::NAME_CAPACITY; k++)
            begin
                ch = e.entry_base[8*(7-k) +: 8];
                if (k == 0 && ch == fds_pkg::CH_KANJI_E5)
                    ch = fds_pkg::CH_DELETED;
                name_buf[n] = ch;
                n++;
            end
            if (xlen > 0 && n < fds_pkg::NAME_CAPACITY)
            begin
                name_buf[n] = fds_pkg::CH_DOT;
                n++;
                for (k = 0; k < xlen && n < fds_pkg::NAME_CAPACITY; k++)
                begin
                    name_buf[n] = e.entry_ext[8*(2-k) +: 8];
                    n++;
                end
            end
            scan_over = 1'b1;
            r.status  = fds_pkg::ST_FOUND;
            r.is_dir  = e.entry_attr[4];
            if (n == 0)
            begin
                predicted_results.push_back(r);
                return;
            end
            for (k = 0; k < n; k++)
            begin
                r.name_char   = name_buf[k];
                r.char_valid  = 1'b1;
                r.last        = (k == n - 1);
                r.name_length = r.last ? 4'(n) : 4'd0;
                predicted_results.push_back(r);
            end
            return;
        end
        predicted_results.push_back(r);
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t ns mismatch in %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report(what, got, want);
    endtask

    task automatic check_result(input fds_pkg::result_t got);
        fds_pkg::result_t want;
        results_seen++;
        if (predicted_results.size() == 0)
        begin
            report("unpredicted result status", 64'(got.status), '0);
            return;
        end
        want = predicted_results.pop_front();
        check_field("status", 64'(got.status), 64'(want.status));
        check_field("first_cluster", 64'(got.first_cluster), 64'(want.first_cluster));
        check_field("is_dir", 64'(got.is_dir), 64'(want.is_dir));
        check_field("file_size", 64'(got.file_size), 64'(want.file_size));
        check_field("name_char", 64'(got.name_char), 64'(want.name_char));
        check_field("char_valid", 64'(got.char_valid), 64'(want.char_valid));
        check_field("name_length", 64'(got.name_length), 64'(want.name_length));
        check_field("last", 64'(got.last), 64'(want.last));
        if (want.status == fds_pkg::ST_FOUND && want.last)
            found_count++;
        if (want.char_valid)
            chars_seen++;
    endtask

    task automatic write_reg(input logic [fds_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [fds_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            fds_pkg::REG_SEARCH_MODE:  by_index   = val[0];
            fds_pkg::REG_TARGET_BASE:  want_base  = val;
            fds_pkg::REG_TARGET_EXT:   want_ext   = val[23:0];
            fds_pkg::REG_TARGET_INDEX: want_index = val[15:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // hold off until every expected result is back, then let the pipeline settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (entry_backlog.size() != 0 || entry_valid || predicted_results.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // entry driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            entry_valid <= 1'b0;
            send_gap    <= 0;
        end
        else
        begin
            if (entry_valid && entry_ready)
            begin
                predict_scan_results(entry);
                accepted_items++;
            end
            if (!entry_valid || entry_ready)
            begin
                if (send_gap > 0 && !calm)
                begin
                    entry_valid <= 1'b0;
                    send_gap    <= send_gap - 1;
                end
                else if (entry_backlog.size() != 0)
                begin
                    entry       <= entry_backlog.pop_front();
                    entry_valid <= 1'b1;
                    send_gap    <= calm ? 0 : pick_gap();
                end
                else
                    entry_valid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            check_result(result);
        if (calm)
        begin
            result_ready <= 1'b1;
            stall_left   <= 0;
        end
        else if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            result_ready <= 1'b1;
            stall_left   <= pick_gap();
        end
    end

    initial
    begin
        fds_pkg::entry_t e;
        logic [63:0]     new_base;
        int              k;
        int              rand_start;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset target is all zeros: nothing can match
        queue_entry(mk(1'b1, "README  ", "TXT", ATTR_ARCHIVE));
        wait_idle();

        write_reg(fds_pkg::REG_TARGET_BASE, "README  ");
        write_reg(fds_pkg::REG_TARGET_EXT, {$urandom, 8'($urandom), "TXT"});
        queue_entry(mk(1'b1, "OTHER   ", "BIN", ATTR_ARCHIVE));
        queue_entry(mk(1'b0, {fds_pkg::CH_DELETED, "EADME  "}, "TXT", ATTR_ARCHIVE));
        queue_entry(mk(1'b0, "README  ", "TXT", fds_pkg::ATTR_LFN));
        queue_entry(mk(1'b0, "README  ", "TXT", ATTR_LABEL));
        queue_entry(mk(1'b0, "README  ", "TXT", 8'hFF));
        queue_entry(mk(1'b0, "README  ", "TXT", ATTR_DIR));
        queue_entry(mk(1'b0, "README  ", "TXT", ATTR_ARCHIVE));
        e = mk(1'b1, "README  ", "TXT", 8'h00);
        e.cluster_high = '1;
        e.cluster_low  = '1;
        e.entry_size   = '1;
        queue_entry(e);
        queue_entry(mk(1'b1, {fds_pkg::CH_END, "EADME  "}, "TXT", ATTR_ARCHIVE));
        queue_entry(mk(1'b0, "README  ", "TXT", ATTR_ARCHIVE));
        wait_idle();

        // leading 0x05 stands for 0xE5; mode keeps only its low bit
        write_reg(fds_pkg::REG_SEARCH_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(fds_pkg::REG_TARGET_BASE, {fds_pkg::CH_DELETED, "ABC    "});
        write_reg(fds_pkg::REG_TARGET_EXT, 64'("   "));
        queue_entry(mk(1'b1, {fds_pkg::CH_KANJI_E5, "ABC    "}, "   ", ATTR_ARCHIVE));
        wait_idle();

        write_reg(fds_pkg::REG_SEARCH_MODE, '1);
        write_reg(fds_pkg::REG_TARGET_INDEX, {48'hFFFF_FFFF_FFFF, 16'h0000});
        queue_entry(mk(1'b1, "A       ", "   ", ATTR_ARCHIVE));
        queue_entry(mk(1'b1, "ABCDEFGH", "XYZ", ATTR_DIR));
        queue_entry(mk(1'b1, "        ", "   ", ATTR_ARCHIVE));
        queue_entry(mk(1'b1, "        ", "TXT", ATTR_ARCHIVE));
        queue_entry(mk(1'b1, {fds_pkg::CH_KANJI_E5, "B CD   "}, "E  ", ATTR_ARCHIVE));
        wait_idle();

        write_reg(fds_pkg::REG_TARGET_INDEX, 64'd2);
        queue_entry(mk(1'b1, "X       ", "   ", ATTR_ARCHIVE));
        queue_entry(mk(1'b0, {fds_pkg::CH_DELETED, "Y      "}, "   ", ATTR_ARCHIVE));
        queue_entry(mk(1'b0, "Y       ", "DAT", ATTR_ARCHIVE));
        queue_entry(mk(1'b0, "LONGNAME", "   ", fds_pkg::ATTR_LFN));
        queue_entry(mk(1'b0, "HIT     ", "Z  ", ATTR_ARCHIVE));
        queue_entry(mk(1'b0, "AFTER   ", "   ", ATTR_ARCHIVE));
        wait_idle();

        write_reg(fds_pkg::REG_SEARCH_MODE, 64'd0);
        write_reg(fds_pkg::REG_TARGET_BASE, '1);
        write_reg(fds_pkg::REG_TARGET_EXT, '1);
        write_reg(fds_pkg::REG_TARGET_INDEX, 64'd65535);
        queue_entry(mk(1'b1, '1, '1, 8'hF7));
        queue_entry(mk(1'b1, '0, '0, 8'h00));
        wait_idle();

        // a deeper index, back to back
        write_reg(fds_pkg::REG_SEARCH_MODE, 64'd1);
        write_reg(fds_pkg::REG_TARGET_INDEX, 64'(LONG_INDEX));
        calm = 1'b1;
        for (k = 0; k < LONG_INDEX; k++)
            queue_entry(visible_entry(k == 0));
        queue_entry(visible_entry(1'b0));
        wait_idle();
        calm = 1'b0;

        rand_start = queued_items;
        while (queued_items - rand_start < RANDOM_ITEMS)
        begin
            wait_idle();
            write_reg(fds_pkg::REG_SEARCH_MODE, {$urandom, $urandom});
            if ($urandom_range(0, 1) != 0)
            begin
                new_base = rand_base();
                if ($urandom_range(0, 4) == 0)
                    new_base[63:56] = fds_pkg::CH_DELETED;
                write_reg(fds_pkg::REG_TARGET_BASE, new_base);
                write_reg(fds_pkg::REG_TARGET_EXT, {$urandom, 8'($urandom), rand_ext()});
            end
            if ($urandom_range(0, 1) != 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    write_reg(fds_pkg::REG_TARGET_INDEX, {$urandom, $urandom});
                else
                    write_reg(fds_pkg::REG_TARGET_INDEX, 64'($urandom_range(0, 6)));
            end
            calm = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 4)) build_scan();
        end
        wait_idle();

        $display("Covered %0d directory entries in both search modes, including one scan of %0d",
                 accepted_items, LONG_INDEX + 1);
        $display("Checked %0d results: %0d entries found, %0d name characters",
                 results_seen, found_count, chars_seen);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timed out with %0d results outstanding", predicted_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
hdl/fds_pkg.sv
hdl/fds_front.sv
hdl/fds_queue.sv
hdl/fds_back.sv
hdl/fat_dir_entry_scanner_core.sv
tb/tb_top.sv
